// ----- design/dlm_pkg.sv -----
package dlm_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int FRAC_BITS   = 12;
    localparam int COL_W       = $clog2(MAX_INPUTS);
    localparam int ROW_W       = $clog2(MAX_OUTPUTS);
    localparam int CELLS       = MAX_INPUTS * MAX_OUTPUTS;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [2:0] {
        CMD_WRITE_WEIGHT = 3'd0,
        CMD_LOAD_INPUT   = 3'd1,
        CMD_LOAD_GRAD    = 3'd2,
        CMD_FORWARD      = 3'd3,
        CMD_BACKWARD     = 3'd4,
        CMD_ACCUMULATE   = 3'd5,
        CMD_READ_GRAD    = 3'd6,
        CMD_NOP          = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        REG_INPUT_COUNT  = 2'd0,
        REG_OUTPUT_COUNT = 2'd1,
        REG_UPDATE_SCALE = 2'd2,
        REG_NONE         = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] result;
        logic [5:0]         index;
        logic               last;
    } t_out_item;

    // One pipeline token passed from the address sequencer to the datapath.
    typedef struct packed {
        logic              vld;
        logic              first;  // first product of a dot product
        logic              emit;   // final product of a dot product
        logic              last;   // final result of the command
        logic [5:0]        index;
        logic [ADDR_W-1:0] addr;
    } t_tok;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -48'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// ----- design/dense_layer_mac_engine.sv -----
// Channel   | Direction | Handshake              | Payload
// command   | in        | i_start, o_busy        | i_item (t_in_item)
// config    | in        | i_cfg_valid, o_cfg_rdy | i_cfg_index, i_cfg_data
// result    | out       | o_strobe (no stall)    | o_item (t_out_item)
//
// Writes and loads complete as they are accepted, with o_busy low. Forward,
// backward and accumulate step through ni*no multiply-accumulates, one a cycle,
// then drain the read, multiply and accumulate pipeline before o_busy falls.
// A read of a gradient word sends a single token through the same pipeline.
// After reset the gradient memory is cleared one word a cycle, all 4096 words,
// with o_busy high; configuration writes are taken throughout.
// Results are one-cycle strobes that the receiver cannot stall.
module dense_layer_mac_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  dlm_pkg::t_in_item             i_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_rdy,
    input  logic [dlm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dlm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output dlm_pkg::t_out_item            o_item
);
    import dlm_pkg::*;

    logic [6:0]         r_ni, r_no;
    logic signed [15:0] r_scale;
    t_cmd               r_cmd;
    t_tok               tok;
    logic               go, busy, clearing, empty;

    assign go        = i_start && !busy;
    assign o_busy    = busy;
    assign o_cfg_rdy = 1'b1;

    // The command stays registered so the datapath knows the mode during drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ni    <= 7'd64;
            r_no    <= 7'd64;
            r_scale <= 16'sd4096;
            r_cmd   <= CMD_NOP;
        end else begin
            if (go) r_cmd <= t_cmd'(i_item.command);
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_INPUT_COUNT:  r_ni    <= i_cfg_data[6:0];
                    REG_OUTPUT_COUNT: r_no    <= i_cfg_data[6:0];
                    REG_UPDATE_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    dlm_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go),
        .i_cmd(t_cmd'(i_item.command)), .i_row(i_item.row), .i_col(i_item.col),
        .i_ni(r_ni), .i_no(r_no), .i_pipe_empty(empty),
        .o_tok(tok), .o_busy(busy), .o_clearing(clearing));

    dlm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(tok), .i_cmd(r_cmd),
        .i_clearing(clearing), .i_wr(i_item), .i_wr_go(go), .i_scale(r_scale),
        .o_empty(empty), .o_strobe(o_strobe), .o_item(o_item));

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy || $past(busy))
        else $error("result while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_strobe)
        else $error("result during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_item.command == CMD_FORWARD) |=> busy)
        else $error("forward did not start");
endmodule

// ----- design/dlm_ram.sv -----
module dlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/dlm_seq.sv -----
// Command sequencer: walks the matrix in the order each command needs and
// emits one address token per cycle.
module dlm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  dlm_pkg::t_cmd      i_cmd,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic [6:0]         i_ni,
    input  logic [6:0]         i_no,
    input  logic               i_pipe_empty,
    output dlm_pkg::t_tok      o_tok,
    output logic               o_busy,
    output logic               o_clearing
);
    import dlm_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [ROW_W-1:0]  r_r;
    logic [COL_W-1:0]  r_c;
    logic [ADDR_W-1:0] r_clr;
    logic [6:0]        r_ni, r_no;
    logic              outer_end, inner_end;

    // Forward iterates columns inside rows; backward rows inside columns.
    always_comb begin
        if (r_cmd == CMD_BACKWARD) begin
            inner_end = ({1'b0, r_r} == r_no - 7'd1);
            outer_end = ({1'b0, r_c} == r_ni - 7'd1);
        end else begin
            inner_end = ({1'b0, r_c} == r_ni - 7'd1);
            outer_end = ({1'b0, r_r} == r_no - 7'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == ADDR_W'(CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_go) begin
                    if (i_cmd inside {CMD_FORWARD, CMD_BACKWARD, CMD_ACCUMULATE}) begin
                        n_state = ST_RUN;
                    end else if (i_cmd == CMD_READ_GRAD) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_RUN:   if (inner_end && outer_end) n_state = ST_DRAIN;
            ST_READ:  n_state = ST_DRAIN;
            ST_DRAIN: if (i_pipe_empty) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_tok       = '0;
        o_tok.addr  = {r_r, r_c};
        o_busy      = (r_state != ST_IDLE);
        o_clearing  = (r_state == ST_CLEAR);
        case (r_state)
            ST_RUN: begin
                o_tok.vld   = 1'b1;
                o_tok.first = (r_cmd == CMD_BACKWARD) ? (r_r == '0) : (r_c == '0);
                o_tok.emit  = inner_end && (r_cmd != CMD_ACCUMULATE);
                o_tok.last  = outer_end;
                o_tok.index = (r_cmd == CMD_BACKWARD) ? 6'(r_c) : 6'(r_r);
            end
            ST_READ: begin
                o_tok.vld   = 1'b1;
                o_tok.first = 1'b1;
                o_tok.emit  = 1'b1;
                o_tok.last  = 1'b1;
                o_tok.index = 6'(r_c);
            end
            ST_CLEAR: o_tok.addr = r_clr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cmd   <= CMD_NOP;
            r_r     <= '0;
            r_c     <= '0;
            r_ni    <= 7'd1;
            r_no    <= 7'd1;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_IDLE && i_go) begin
                r_cmd <= i_cmd;
                r_ni  <= (i_ni == 7'd0) ? 7'd1 : (i_ni > 7'(MAX_INPUTS) ? 7'(MAX_INPUTS) : i_ni);
                r_no  <= (i_no == 7'd0) ? 7'd1 : (i_no > 7'(MAX_OUTPUTS) ? 7'(MAX_OUTPUTS) : i_no);
                if (i_cmd == CMD_READ_GRAD) begin
                    r_r <= ROW_W'(i_row);
                    r_c <= COL_W'(i_col);
                end else begin
                    r_r <= '0;
                    r_c <= '0;
                end
            end else if (r_state == ST_RUN) begin
                if (r_cmd == CMD_BACKWARD) begin
                    r_r <= inner_end ? '0 : r_r + 1'b1;
                    if (inner_end) r_c <= r_c + 1'b1;
                end else begin
                    r_c <= inner_end ? '0 : r_c + 1'b1;
                    if (inner_end) r_r <= r_r + 1'b1;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.vld |-> !o_clearing)
        else $error("token issued during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.vld && o_tok.last && o_tok.emit && r_state == ST_RUN) |=> r_state == ST_DRAIN)
        else $error("run did not end on last result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !i_go) |=> r_state == ST_IDLE)
        else $error("left idle without a command");
endmodule

// ----- design/dlm_datapath.sv -----
// Read-modify-write datapath. Stage 0 issues reads, stage 1 sees RAM data,
// stage 2 holds the registered product, stage 3 accumulates or writes back.
module dlm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlm_pkg::t_tok       i_tok,
    input  dlm_pkg::t_cmd       i_cmd,
    input  logic                i_clearing,
    input  dlm_pkg::t_in_item   i_wr,
    input  logic                i_wr_go,
    input  logic signed [15:0]  i_scale,
    output logic                o_empty,
    output logic                o_strobe,
    output dlm_pkg::t_out_item  o_item
);
    import dlm_pkg::*;

    logic signed [15:0] w_q, g_q, x_q, gv_q;
    t_tok               r_t1, r_t2, r_t3;
    logic signed [31:0] r_p2;
    logic signed [15:0] r_gw2, r_gw3;
    logic signed [47:0] r_p3;
    logic signed [31:0] r_acc;
    logic               r_strobe;
    t_out_item          r_item;
    logic signed [15:0] vec_q;
    logic               accum, rd;
    logic signed [15:0] upd;
    logic signed [32:0] sum;
    logic signed [31:0] acc_n;
    logic               w_we, x_we, g_we, gw_we;
    logic [ADDR_W-1:0]  gw_waddr;
    logic signed [15:0] gw_wdata;
    logic [COL_W-1:0]   x_ra;
    logic [ROW_W-1:0]   g_ra;

    assign accum = (i_cmd == CMD_ACCUMULATE);
    assign rd    = (i_cmd == CMD_READ_GRAD);

    assign w_we = i_wr_go && i_wr.command == CMD_WRITE_WEIGHT;
    assign x_we = i_wr_go && i_wr.command == CMD_LOAD_INPUT;
    assign g_we = i_wr_go && i_wr.command == CMD_LOAD_GRAD;

    assign x_ra = i_tok.addr[COL_W-1:0];
    assign g_ra = i_tok.addr[ADDR_W-1:COL_W];

    dlm_ram #(.WIDTH(16), .DEPTH(CELLS)) u_w (
        .i_clk(i_clk), .i_we(w_we), .i_waddr({ROW_W'(i_wr.row), COL_W'(i_wr.col)}),
        .i_wdata(i_wr.value), .i_raddr(i_tok.addr), .o_rdata(w_q));
    dlm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_x (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(COL_W'(i_wr.col)),
        .i_wdata(i_wr.value), .i_raddr(x_ra), .o_rdata(x_q));
    dlm_ram #(.WIDTH(16), .DEPTH(MAX_OUTPUTS)) u_g (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(ROW_W'(i_wr.row)),
        .i_wdata(i_wr.value), .i_raddr(g_ra), .o_rdata(gv_q));
    dlm_ram #(.WIDTH(16), .DEPTH(CELLS)) u_gw (
        .i_clk(i_clk), .i_we(gw_we), .i_waddr(gw_waddr),
        .i_wdata(gw_wdata), .i_raddr(i_tok.addr), .o_rdata(g_q));

    // Forward pairs weights with x, backward with g. Accumulate forms x*g.
    assign vec_q = (i_cmd == CMD_BACKWARD) ? gv_q : x_q;

    // Each cell is visited once per accumulate, so write-back never races a read.
    // The clearing pass writes the sequencer's clear address directly.
    assign upd = sat16(r_p3 >>> (2 * FRAC_BITS));
    assign sum = 33'(r_gw3) + 33'(upd);
    assign gw_we    = i_clearing || (r_t3.vld && accum);
    assign gw_waddr = i_clearing ? i_tok.addr : r_t3.addr;
    assign gw_wdata = i_clearing ? 16'sd0 : sat16(48'(sum));
    assign o_empty  = !r_t1.vld && !r_t2.vld && !r_t3.vld;

    always_comb begin
        logic signed [32:0] s;
        s = (r_t3.first ? 33'sd0 : 33'(r_acc)) + 33'(signed'(r_p3[31:0]));
        if (s > 33'sd2147483647) begin
            acc_n = 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483648) begin
            acc_n = 32'sh80000000;
        end else begin
            acc_n = s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1     <= '0;
            r_t2     <= '0;
            r_t3     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_t1     <= i_tok;
            r_t2     <= r_t1;
            r_t3     <= r_t2;
            r_strobe <= r_t3.vld && r_t3.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2  <= accum ? 32'(x_q) * 32'(gv_q) : 32'(w_q) * 32'(vec_q);
        r_gw2 <= g_q;
        r_gw3 <= r_gw2;
        r_p3  <= accum ? 48'(r_p2) * 48'(i_scale) : 48'(r_p2);
        if (r_t3.vld) r_acc <= acc_n;
        if (r_t3.vld && r_t3.emit) begin
            r_item.index <= r_t3.index;
            r_item.last  <= r_t3.last;
            r_item.result <= rd ? r_gw3 : sat16(48'(acc_n >>> FRAC_BITS));
        end
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_t3.vld))
        else $error("result without token");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gw_we |-> !(w_we || x_we || g_we) || i_clearing)
        else $error("gradient write overlaps a load");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.last) |=> !o_strobe)
        else $error("result after last");
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the dense layer MAC engine.
// A driver pulls commands from a queue and transfers each one when the engine is
// not busy. A monitor takes every strobed result and compares it with the oldest
// prediction. The predictor keeps its own copy of the weights, gradient store,
// vectors and registers, and works out each command's results on acceptance.
module tb_top;
    import dlm_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    t_in_item i_item = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_rdy;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_strobe;
    t_out_item o_item;

    always #1 i_clk = ~i_clk;

    dense_layer_mac_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .i_cfg_valid(i_cfg_valid), .o_cfg_rdy(o_cfg_rdy),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_item(o_item)
    );

    // Predictor state: the engine's memories, vectors and registers.
    logic signed [15:0] weights [CELLS];
    logic signed [15:0] grad_words [CELLS];
    logic signed [15:0] x_vec [MAX_INPUTS];
    logic signed [15:0] g_vec [MAX_OUTPUTS];
    logic [6:0] cols_reg;
    logic [6:0] rows_reg;
    logic signed [15:0] scale_reg;

    t_in_item pending_cmds[$];
    t_out_item expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int cmds_sent = 0;
    longint cycle_count = 0;

    function automatic int used_count(input logic [6:0] v, input int max_v);
        if (v == 0) begin
            return 1;
        end
        return (v > max_v) ? max_v : int'(v);
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Arithmetic shift on a signed longint rounds toward minus infinity.
    function automatic logic signed [15:0] dot_out(input longint acc);
        return clip16(acc >>> FRAC_BITS);
    endfunction

    task automatic predict_command(input t_in_item it);
        int ni;
        int no;
        longint acc;
        longint p;
        t_out_item r;
        ni = used_count(cols_reg, MAX_INPUTS);
        no = used_count(rows_reg, MAX_OUTPUTS);
        case (t_cmd'(it.command))
            CMD_WRITE_WEIGHT: weights[it.row * MAX_INPUTS + it.col] = it.value;
            CMD_LOAD_INPUT: x_vec[it.col] = it.value;
            CMD_LOAD_GRAD: g_vec[it.row] = it.value;
            CMD_FORWARD: begin
                for (int rr = 0; rr < no; rr++) begin
                    acc = 0;
                    for (int cc = 0; cc < ni; cc++) begin
                        acc = clip32(acc + longint'(weights[rr * MAX_INPUTS + cc]) *
                                     longint'(x_vec[cc]));
                    end
                    r.result = dot_out(acc);
                    r.index = rr[5:0];
                    r.last = (rr == no - 1);
                    expected_results.push_back(r);
                end
            end
            CMD_BACKWARD: begin
                for (int cc = 0; cc < ni; cc++) begin
                    acc = 0;
                    for (int rr = 0; rr < no; rr++) begin
                        acc = clip32(acc + longint'(weights[rr * MAX_INPUTS + cc]) *
                                     longint'(g_vec[rr]));
                    end
                    r.result = dot_out(acc);
                    r.index = cc[5:0];
                    r.last = (cc == ni - 1);
                    expected_results.push_back(r);
                end
            end
            CMD_ACCUMULATE: begin
                for (int rr = 0; rr < no; rr++) begin
                    for (int cc = 0; cc < ni; cc++) begin
                        p = longint'(scale_reg) * longint'(x_vec[cc]) * longint'(g_vec[rr]);
                        grad_words[rr * MAX_INPUTS + cc] = clip16(
                            longint'(grad_words[rr * MAX_INPUTS + cc]) +
                            longint'(clip16(p >>> (2 * FRAC_BITS))));
                    end
                end
            end
            CMD_READ_GRAD: begin
                r.result = grad_words[it.row * MAX_INPUTS + it.col];
                r.index = it.col;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of back-to-back transfers separated by random gaps.
    // The item on the bus is always the head of the queue until it is taken.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predict_command(i_item);
                void'(pending_cmds.pop_front());
                cmds_sent <= cmds_sent + 1;
            end
            // The item on the bus stays there until it is taken.
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                i_item <= pending_cmds[0];
                i_start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: results cannot be stalled, so every strobe is checked at once.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                errors <= errors + 1;
                $display("%0t: unexpected result %p", $time, o_item);
            end else begin
                if (o_item !== expected_results[0]) begin
                    errors <= errors + 1;
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_results[0], o_item);
                end
                void'(expected_results.pop_front());
            end
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_in_item make_cmd(input t_cmd c, input int r, input int k,
                                          input logic [15:0] v);
        t_in_item it;
        it.command = c;
        it.row = r[5:0];
        it.col = k[5:0];
        it.value = v;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_start || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Accumulate emits nothing, so give the engine time to finish its walk.
        repeat (4200) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_rdy);
        case (idx)
            REG_INPUT_COUNT: cols_reg = v[6:0];
            REG_OUTPUT_COUNT: rows_reg = v[6:0];
            REG_UPDATE_SCALE: scale_reg = v;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Loads every weight and vector entry the current sizes touch, so no
    // unwritten location is ever read.
    task automatic fill_all(input int nr, input int nc);
        for (int k = 0; k < nc; k++) begin
            pending_cmds.push_back(make_cmd(CMD_LOAD_INPUT, $urandom_range(0, 63), k,
                                            16'($urandom())));
        end
        for (int rr = 0; rr < nr; rr++) begin
            pending_cmds.push_back(make_cmd(CMD_LOAD_GRAD, rr, $urandom_range(0, 63),
                                            16'($urandom())));
            for (int k = 0; k < nc; k++) begin
                pending_cmds.push_back(make_cmd(CMD_WRITE_WEIGHT, rr, k,
                                                16'($urandom())));
            end
        end
    endtask

    task automatic random_phase(input int n, input int nr, input int nc);
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            c = t_cmd'($urandom_range(0, 7));
            // Large sizes make the walking commands slow, so use them rarely.
            if ((c == CMD_FORWARD || c == CMD_BACKWARD || c == CMD_ACCUMULATE) &&
                nr * nc > 256 && $urandom_range(0, 3) != 0) begin
                c = CMD_READ_GRAD;
            end
            pending_cmds.push_back(make_cmd(c, $urandom_range(0, nr - 1),
                                            $urandom_range(0, nc - 1),
                                            16'($urandom())));
        end
    endtask

    // Every phase stays inside the rows and columns loaded once at the start.
    int sizes_r[5] = '{6, 1, 3, 6, 5};
    int sizes_c[5] = '{8, 1, 8, 2, 7};
    logic [15:0] scales[5] = '{16'h1000, 16'h7FFF, 16'h8000, 16'hF800, 16'h0123};

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            weights[i] = '0;
            grad_words[i] = '0;
        end
        cols_reg = 7'd64;
        rows_reg = 7'd64;
        scale_reg = 16'sh1000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes of the data and every command.
        write_reg(REG_INPUT_COUNT, 16'(sizes_c[0]));
        write_reg(REG_OUTPUT_COUNT, 16'(sizes_r[0]));
        fill_all(sizes_r[0], sizes_c[0]);
        pending_cmds.push_back(make_cmd(CMD_READ_GRAD, 0, 0, 16'h0));
        pending_cmds.push_back(make_cmd(CMD_READ_GRAD, 63, 63, 16'hFFFF));
        pending_cmds.push_back(make_cmd(CMD_NOP, 63, 63, 16'h7FFF));
        pending_cmds.push_back(make_cmd(CMD_LOAD_INPUT, 0, 7, 16'h7FFF));
        pending_cmds.push_back(make_cmd(CMD_LOAD_GRAD, 5, 0, 16'h8000));
        pending_cmds.push_back(make_cmd(CMD_WRITE_WEIGHT, 5, 7, 16'h8000));
        pending_cmds.push_back(make_cmd(CMD_WRITE_WEIGHT, 0, 0, 16'h7FFF));
        pending_cmds.push_back(make_cmd(CMD_FORWARD, 0, 0, 16'h0));
        pending_cmds.push_back(make_cmd(CMD_BACKWARD, 0, 0, 16'h0));
        pending_cmds.push_back(make_cmd(CMD_ACCUMULATE, 0, 0, 16'h0));
        pending_cmds.push_back(make_cmd(CMD_READ_GRAD, 5, 7, 16'h0));
        pending_cmds.push_back(make_cmd(CMD_READ_GRAD, 0, 63, 16'h0));
        wait_drained();

        // Several register settings, including a count of zero.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_INPUT_COUNT, (ph == 1) ? 16'd0 : 16'(sizes_c[ph]));
            write_reg(REG_OUTPUT_COUNT, 16'(sizes_r[ph]));
            write_reg(REG_UPDATE_SCALE, scales[ph]);
            if (ph == 4) begin
                write_reg(REG_NONE, 16'hFFFF);
            end
            pending_cmds.push_back(make_cmd(CMD_ACCUMULATE, 0, 0, 16'h0));
            random_phase(12, sizes_r[ph], sizes_c[ph]);
            wait_drained();
        end
        $display("Sent %0d commands over five register settings; checked %0d results.",
                 cmds_sent, results_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
